// ===== rtl/assert_macros.svh =====
// assertion macros shared by the slot table modules
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PSES_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slot table assertion failed");

// antecedent implies consequent in the next cycle
`define PSES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slot table assertion failed");

`endif

// ===== rtl/pses_pkg.sv =====
`timescale 1ns / 1ps
// types, codes and the colour class function of the per-source event slot table
// no dependencies
package pses_pkg;

	localparam int SEQ_W      = 32;
	localparam int SRC_W      = 16;
	localparam int CODE_W     = 4;
	localparam int AFF_W      = 8;
	localparam int TIME_W     = 48;
	localparam int SLOT_NUM_W = 6;
	localparam int PLACE_W    = 2;
	localparam int COLOUR_W   = 2;
	localparam int ENTRY_W    = SRC_W + SEQ_W + COLOUR_W;

	localparam logic [SRC_W-1:0] INV_SRC_RESET = 16'hFFFF;

	localparam logic [PLACE_W-1:0] PL_HIT   = 2'd0;
	localparam logic [PLACE_W-1:0] PL_FREE  = 2'd1;
	localparam logic [PLACE_W-1:0] PL_EVICT = 2'd2;
	localparam logic [PLACE_W-1:0] PL_NONE  = 2'd3;

	localparam logic [COLOUR_W-1:0] COL_NEUTRAL = 2'd0;
	localparam logic [COLOUR_W-1:0] COL_RUNNING = 2'd1;
	localparam logic [COLOUR_W-1:0] COL_WAITING = 2'd2;
	localparam logic [COLOUR_W-1:0] COL_ERROR   = 2'd3;

	localparam logic [CODE_W-1:0] LC_QUEUED    = 4'd3;
	localparam logic [CODE_W-1:0] LC_RUNNING   = 4'd4;
	localparam logic [CODE_W-1:0] LC_RESULT    = 4'd5;
	localparam logic [CODE_W-1:0] LC_ACCEPTED  = 4'd6;
	localparam logic [CODE_W-1:0] LC_ADOPTED   = 4'd7;
	localparam logic [CODE_W-1:0] LC_DISCARDED = 4'd8;
	localparam logic [CODE_W-1:0] LC_STOPPING  = 4'd9;

	typedef struct packed {
		logic load;
		logic check;
		logic scan_start;
		logic scan_rd;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic drop;
		logic scan_last;
		logic out_busy;
	} status_t;

	function automatic logic [COLOUR_W-1:0] colour_of(
		input logic [CODE_W-1:0] code,
		input logic [AFF_W-1:0]  aff
	);
		logic [COLOUR_W-1:0] c;
		c = COL_NEUTRAL;
		case (code) inside
			LC_RUNNING, LC_ADOPTED:             c = COL_RUNNING;
			LC_QUEUED, LC_RESULT, LC_ACCEPTED:  c = COL_WAITING;
			LC_DISCARDED, LC_STOPPING:          c = COL_ERROR;
			default:                            c = COL_NEUTRAL;
		endcase
		// affinity failure overrides the lifecycle code
		if (!aff[AFF_W-1] && (aff[AFF_W-2:0] != '0)) begin
			c = COL_ERROR;
		end
		return c;
	endfunction

endpackage

// ===== rtl/per_source_event_slot_table.sv =====
`timescale 1ns / 1ps
// top level of the per-source event slot table
// depends on pses_pkg, pses_ctrl, pses_dp and pses_ram
//
// Lifecycle events come in on the in channel (in_valid / in_stall) and one result
// per event leaves on the out channel (out_valid / out_stall). An item is taken at
// an edge with valid high and stall low.
// An event with a sequence not above the last one, or from the invalid source id,
// gives a not-taken result without a slot scan. Any other event scans all
// SLOT_COUNT slots one per cycle through the slot store read port and then
// shows its result. The next event is taken only once the result of the
// current one has entered the output register.
// A result waits in the output register while out_stall is high; the next event
// is still taken and held until that register is free.
// The invalid source id is written on the cfg channel (cfg_valid / cfg_ready,
// ready always high); write it only while no item is in flight, the block does
// not enforce this. Reset clears the last sequence, the time origin, all slot
// valid bits and sets the invalid source id to all ones; the block is then ready.
module per_source_event_slot_table #(
	parameter int SLOT_COUNT = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pses_pkg::SRC_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [pses_pkg::SEQ_W-1:0]          event_sequence,
	input  logic [pses_pkg::SRC_W-1:0]          source_id,
	input  logic [pses_pkg::CODE_W-1:0]         lifecycle_code,
	input  logic signed [pses_pkg::AFF_W-1:0]   affinity_status,
	input  logic [pses_pkg::TIME_W-1:0]         event_time_us,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                taken,
	output logic [pses_pkg::SLOT_NUM_W-1:0]     slot_number,
	output logic [pses_pkg::PLACE_W-1:0]        placement,
	output logic [pses_pkg::COLOUR_W-1:0]       colour_class,
	output logic [pses_pkg::TIME_W-1:0]         elapsed_us
);

	pses_pkg::cmd_t    cmd;
	pses_pkg::status_t status;

	assign cfg_ready = 1'b1;

	pses_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pses_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.event_sequence  (event_sequence),
		.source_id       (source_id),
		.lifecycle_code  (lifecycle_code),
		.affinity_status (affinity_status),
		.event_time_us   (event_time_us),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.taken           (taken),
		.slot_number     (slot_number),
		.placement       (placement),
		.colour_class    (colour_class),
		.elapsed_us      (elapsed_us)
	);

endmodule

// ===== rtl/pses_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read data
// no dependencies
module pses_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/pses_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine of the slot table: accept, check, scan, commit
// depends on pses_pkg and assert_macros.svh
`include "assert_macros.svh"

module pses_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pses_pkg::status_t status,
	output pses_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check      = 1'b1;
				cmd.scan_start = 1'b1;
				state_d        = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.drop) begin
					state_d = ST_DONE;
				end else begin
					cmd.scan_rd = 1'b1;
					if (status.scan_last) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!status.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`PSES_ASSERT_NEXT(a_scan_moves, clk, arst_n, state_q == ST_SCAN,
		state_q == ST_SCAN || state_q == ST_DRAIN || state_q == ST_DONE)
	`PSES_ASSERT_NEXT(a_commit_idle, clk, arst_n, cmd.commit, state_q == ST_IDLE)

endmodule

// ===== rtl/pses_dp.sv =====
`timescale 1ns / 1ps
// datapath of the slot table: item registers, slot scan, slot store, result register
// depends on pses_pkg, pses_ram and assert_macros.svh
`include "assert_macros.svh"

module pses_dp #(
	parameter int SLOT_COUNT = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pses_pkg::cmd_t                      cmd,
	output pses_pkg::status_t                   status,
	input  logic                                cfg_valid,
	input  logic [pses_pkg::SRC_W-1:0]          cfg_data,
	input  logic [pses_pkg::SEQ_W-1:0]          event_sequence,
	input  logic [pses_pkg::SRC_W-1:0]          source_id,
	input  logic [pses_pkg::CODE_W-1:0]         lifecycle_code,
	input  logic signed [pses_pkg::AFF_W-1:0]   affinity_status,
	input  logic [pses_pkg::TIME_W-1:0]         event_time_us,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic                                taken,
	output logic [pses_pkg::SLOT_NUM_W-1:0]     slot_number,
	output logic [pses_pkg::PLACE_W-1:0]        placement,
	output logic [pses_pkg::COLOUR_W-1:0]       colour_class,
	output logic [pses_pkg::TIME_W-1:0]         elapsed_us
);

	localparam int AW   = $clog2(SLOT_COUNT);
	localparam int SNW  = pses_pkg::SLOT_NUM_W;
	localparam int SEQW = pses_pkg::SEQ_W;
	localparam int SRCW = pses_pkg::SRC_W;
	localparam int TW   = pses_pkg::TIME_W;
	localparam int CW   = pses_pkg::COLOUR_W;
	localparam int EW   = pses_pkg::ENTRY_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(SLOT_COUNT - 1);

	logic [SEQW-1:0]               ev_seq_q;
	logic [SRCW-1:0]               ev_src_q;
	logic [pses_pkg::CODE_W-1:0]   ev_code_q;
	logic [pses_pkg::AFF_W-1:0]    ev_aff_q;
	logic [TW-1:0]                 ev_time_q;

	logic [SEQW-1:0]       last_seq_q;
	logic [TW-1:0]         origin_q;
	logic [SRCW-1:0]       inv_src_q;
	logic                  drop_q;
	logic [SLOT_COUNT-1:0] slot_valid_q;

	logic [AW-1:0]   cnt_q;
	logic            rd_valid_s1;
	logic [AW-1:0]   idx_s1;
	logic            hit_q;
	logic [AW-1:0]   hit_idx_q;
	logic            free_q;
	logic [AW-1:0]   free_idx_q;
	logic [AW-1:0]   min_idx_q;
	logic [SEQW-1:0] min_seq_q;

	logic [EW-1:0]   rd_data;
	logic [SRCW-1:0] rd_src;
	logic [SEQW-1:0] rd_seq;
	logic            rd_slot_valid;

	logic [AW-1:0]                  sel_idx;
	logic [pses_pkg::PLACE_W-1:0]   sel_place;
	logic [CW-1:0]                  colour;
	logic [TW:0]                    diff;
	logic [TW-1:0]                  elapsed;
	logic [EW-1:0]                  wr_data;
	logic                           wr_en;

	logic                           out_valid_q;
	logic                           taken_q;
	logic [SNW-1:0]                 slot_number_q;
	logic [pses_pkg::PLACE_W-1:0]   placement_q;
	logic [CW-1:0]                  colour_q;
	logic [TW-1:0]                  elapsed_q;

	assign status.drop      = drop_q;
	assign status.scan_last = (cnt_q == LAST_IDX);
	assign status.out_busy  = out_valid_q && out_stall;

	assign rd_src        = rd_data[EW-1 -: SRCW];
	assign rd_seq        = rd_data[CW +: SEQW];
	assign rd_slot_valid = slot_valid_q[idx_s1];

	// slot choice: same source, then first free, then oldest
	always_comb begin
		if (hit_q) begin
			sel_idx   = hit_idx_q;
			sel_place = pses_pkg::PL_HIT;
		end else if (free_q) begin
			sel_idx   = free_idx_q;
			sel_place = pses_pkg::PL_FREE;
		end else begin
			sel_idx   = min_idx_q;
			sel_place = pses_pkg::PL_EVICT;
		end
	end

	assign colour  = pses_pkg::colour_of(ev_code_q, ev_aff_q);
	assign diff    = {1'b0, ev_time_q} - {1'b0, origin_q};
	assign elapsed = ((origin_q == '0) || diff[TW]) ? '0 : diff[TW-1:0];
	assign wr_data = {ev_src_q, ev_seq_q, colour};
	assign wr_en   = cmd.commit && !drop_q;

	pses_ram #(
		.WIDTH (EW),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (sel_idx),
		.wdata (wr_data),
		.re    (cmd.scan_rd),
		.raddr (cnt_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ev_seq_q  <= event_sequence;
			ev_src_q  <= source_id;
			ev_code_q <= lifecycle_code;
			ev_aff_q  <= affinity_status;
			ev_time_q <= event_time_us;
		end
		idx_s1 <= cnt_q;
		if (rd_valid_s1 && (idx_s1 == '0 || rd_seq < min_seq_q)) begin
			min_idx_q <= idx_s1;
			min_seq_q <= rd_seq;
		end
		if (rd_valid_s1 && !hit_q) begin
			hit_idx_q <= idx_s1;
		end
		if (rd_valid_s1 && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.commit) begin
			taken_q       <= !drop_q;
			slot_number_q <= drop_q ? '0 : SNW'(sel_idx);
			placement_q   <= drop_q ? pses_pkg::PL_NONE : sel_place;
			colour_q      <= drop_q ? pses_pkg::COL_NEUTRAL : colour;
			elapsed_q     <= drop_q ? '0 : elapsed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q   <= '0;
			origin_q     <= '0;
			inv_src_q    <= pses_pkg::INV_SRC_RESET;
			drop_q       <= 1'b0;
			slot_valid_q <= '0;
			cnt_q        <= '0;
			rd_valid_s1  <= 1'b0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				inv_src_q <= cfg_data;
			end
			if (cmd.check) begin
				if (ev_seq_q > last_seq_q) begin
					last_seq_q <= ev_seq_q;
				end
				drop_q <= (ev_seq_q <= last_seq_q) || (ev_src_q == inv_src_q);
			end
			if (cmd.scan_start) begin
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (cmd.scan_rd && cnt_q != LAST_IDX) begin
				cnt_q <= cnt_q + AW'(1);
			end
			rd_valid_s1 <= cmd.scan_rd;
			if (rd_valid_s1 && rd_slot_valid && rd_src == ev_src_q) begin
				hit_q <= 1'b1;
			end
			if (rd_valid_s1 && !rd_slot_valid) begin
				free_q <= 1'b1;
			end
			if (wr_en) begin
				slot_valid_q[sel_idx] <= 1'b1;
				if (origin_q == '0) begin
					origin_q <= ev_time_q;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign taken        = taken_q;
	assign slot_number  = slot_number_q;
	assign placement    = placement_q;
	assign colour_class = colour_q;
	assign elapsed_us   = elapsed_q;

	`PSES_ASSERT_SAME(a_commit_free, clk, arst_n, cmd.commit, !status.out_busy)
	`PSES_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, out_valid_q)
	`PSES_ASSERT_SAME(a_miss_zero, clk, arst_n, out_valid_q && !taken_q,
		placement_q == pses_pkg::PL_NONE && elapsed_q == '0)

endmodule

// ===== sim/per_source_event_slot_table_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the per-source event slot table: a directed table, then random
// lifecycle events in four register settings, with random sender gaps and random out stalls
// depends on pses_pkg and per_source_event_slot_table
module per_source_event_slot_table_tb;
	import pses_pkg::*;

	localparam int SLOTS = 8;

	localparam logic [CODE_W-1:0] LC_CREATED  = 4'd0;
	localparam logic [CODE_W-1:0] LC_ASSIGNED = 4'd1;
	localparam logic [CODE_W-1:0] LC_IDLE     = 4'd2;
	localparam logic [CODE_W-1:0] LC_FINISHED = 4'd10;
	localparam logic [CODE_W-1:0] LC_TOP      = 4'd15;

	typedef struct packed {
		logic [SEQ_W-1:0]         seq;
		logic [SRC_W-1:0]         src;
		logic [CODE_W-1:0]        code;
		logic signed [AFF_W-1:0]  aff;
		logic [TIME_W-1:0]        t;
	} lifecycle_event_t;

	typedef struct packed {
		logic                     taken;
		logic [SLOT_NUM_W-1:0]    slot;
		logic [PLACE_W-1:0]       place;
		logic [COLOUR_W-1:0]      colour;
		logic [TIME_W-1:0]        elapsed;
	} slot_result_t;

	typedef struct packed {
		lifecycle_event_t ev;
		logic             pinned;
		slot_result_t     want;
	} directed_row_t;

	localparam slot_result_t NOT_TAKEN = '{1'b0, 6'd0, PL_NONE, COL_NEUTRAL, 48'd0};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [SRC_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [SEQ_W-1:0]        event_sequence = '0;
	logic [SRC_W-1:0]        source_id = '0;
	logic [CODE_W-1:0]       lifecycle_code = '0;
	logic signed [AFF_W-1:0] affinity_status = '0;
	logic [TIME_W-1:0]       event_time_us = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    taken;
	logic [SLOT_NUM_W-1:0]   slot_number;
	logic [PLACE_W-1:0]      placement;
	logic [COLOUR_W-1:0]     colour_class;
	logic [TIME_W-1:0]       elapsed_us;

	// predicted table state
	logic [SRC_W-1:0]  invalid_src_copy = INV_SRC_RESET;
	logic [SEQ_W-1:0]  seen_seq = '0;
	logic [TIME_W-1:0] origin_us = '0;
	logic              slot_live [SLOTS];
	logic [SRC_W-1:0]  slot_owner [SLOTS];
	logic [SEQ_W-1:0]  slot_seq_no [SLOTS];

	slot_result_t      expected_results [$];
	int                mismatches = 0;
	bit                calm = 1'b0;
	bit                sending = 1'b0;
	int                stall_hold = 0;
	int                stall_pick;
	logic [SEQ_W-1:0]  seq_head = 32'd20;
	logic [TIME_W-1:0] time_head = 48'd5000;
	logic [SRC_W-1:0]  source_pool [12];
	directed_row_t     opening_rows [15];

	per_source_event_slot_table #(.SLOT_COUNT(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.event_sequence(event_sequence),
		.source_id(source_id),
		.lifecycle_code(lifecycle_code),
		.affinity_status(affinity_status),
		.event_time_us(event_time_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.taken(taken),
		.slot_number(slot_number),
		.placement(placement),
		.colour_class(colour_class),
		.elapsed_us(elapsed_us)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_owner[i] = '0;
			slot_seq_no[i] = '0;
		end
	end

	function automatic logic [COLOUR_W-1:0] colour_for(input logic [CODE_W-1:0] code,
			input logic signed [AFF_W-1:0] aff);
		if (aff > 0) begin
			return COL_ERROR;
		end
		case (code)
			LC_RUNNING, LC_ADOPTED: return COL_RUNNING;
			LC_QUEUED, LC_RESULT, LC_ACCEPTED: return COL_WAITING;
			LC_DISCARDED, LC_STOPPING: return COL_ERROR;
			default: return COL_NEUTRAL;
		endcase
	endfunction

	function automatic slot_result_t place_event(input lifecycle_event_t ev);
		slot_result_t res;
		int pick;
		logic [PLACE_W-1:0] how;
		res = NOT_TAKEN;
		how = PL_NONE;
		if (ev.seq <= seen_seq) begin
			return res;
		end
		seen_seq = ev.seq;
		if (ev.src == invalid_src_copy) begin
			return res;
		end
		pick = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (pick < 0 && slot_live[i] && slot_owner[i] == ev.src) begin
				pick = i;
				how = PL_HIT;
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (pick < 0 && !slot_live[i]) begin
				pick = i;
				how = PL_FREE;
			end
		end
		if (pick < 0) begin
			pick = 0;
			how = PL_EVICT;
			for (int i = 1; i < SLOTS; i++) begin
				if (slot_seq_no[i] < slot_seq_no[pick]) begin
					pick = i;
				end
			end
		end
		// an origin of zero reads as not latched
		if (origin_us == '0) begin
			origin_us = ev.t;
		end
		res.taken = 1'b1;
		res.slot = SLOT_NUM_W'(pick);
		res.place = how;
		res.colour = colour_for(ev.code, ev.aff);
		res.elapsed = (ev.t >= origin_us) ? ev.t - origin_us : '0;
		slot_live[pick] = 1'b1;
		slot_owner[pick] = ev.src;
		slot_seq_no[pick] = ev.seq;
		return res;
	endfunction

	function automatic lifecycle_event_t random_event();
		lifecycle_event_t ev;
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			ev.seq = $urandom_range(0, seq_head);
		end else begin
			seq_head = seq_head + (($urandom_range(0, 19) == 0) ?
				$urandom_range(1, 65536) : $urandom_range(1, 3));
			ev.seq = seq_head;
		end
		r = $urandom_range(0, 99);
		if (r < 70) begin
			ev.src = source_pool[$urandom_range(0, 11)];
		end else if (r < 80) begin
			ev.src = invalid_src_copy;
		end else begin
			ev.src = SRC_W'($urandom);
		end
		if ($urandom_range(0, 9) == 0) begin
			ev.code = CODE_W'($urandom_range(LC_FINISHED + 1, LC_TOP));
		end else begin
			ev.code = CODE_W'($urandom_range(LC_CREATED, LC_FINISHED));
		end
		case ($urandom_range(0, 3))
			0: ev.aff = '0;
			1: ev.aff = AFF_W'(-$urandom_range(1, 128));
			default: ev.aff = AFF_W'($urandom);
		endcase
		r = $urandom_range(0, 9);
		if (r == 0) begin
			ev.t = TIME_W'({$urandom, $urandom});
		end else if (r == 1) begin
			ev.t = time_head - $urandom_range(0, 1000);
		end else begin
			time_head = time_head + $urandom_range(0, 5000);
			ev.t = time_head;
		end
		return ev;
	endfunction

	function automatic int sender_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 60) begin
			$display("%0t ns: mismatch: %s", $time, msg);
		end
	endtask

	task automatic lower_valid();
		if (sending) begin
			in_valid <= 1'b0;
			sending = 1'b0;
		end
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			lower_valid();
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		lower_valid();
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic send_event(input lifecycle_event_t ev, input logic pinned,
			input slot_result_t want);
		slot_result_t predicted;
		bit accepted;
		in_valid <= 1'b1;
		sending = 1'b1;
		event_sequence <= ev.seq;
		source_id <= ev.src;
		lifecycle_code <= ev.code;
		affinity_status <= ev.aff;
		event_time_us <= ev.t;
		accepted = 1'b0;
		while (!accepted) begin
			@(negedge clk);
			accepted = !in_stall;
			@(posedge clk);
		end
		predicted = place_event(ev);
		expected_results = {expected_results, (pinned ? want : predicted)};
	endtask

	task automatic write_invalid_source(input logic [SRC_W-1:0] value);
		bit accepted;
		cfg_valid <= 1'b1;
		cfg_data <= value;
		accepted = 1'b0;
		while (!accepted) begin
			@(negedge clk);
			accepted = cfg_ready;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		invalid_src_copy = value;
	endtask

	task automatic check_result();
		slot_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result item with nothing expected");
			return;
		end
		want = expected_results.pop_front();
		if (taken !== want.taken)
			report_mismatch($sformatf("taken %b, want %b", taken, want.taken));
		if (slot_number !== want.slot)
			report_mismatch($sformatf("slot_number %0d, want %0d", slot_number, want.slot));
		if (placement !== want.place)
			report_mismatch($sformatf("placement %0d, want %0d", placement, want.place));
		if (colour_class !== want.colour)
			report_mismatch($sformatf("colour_class %0d, want %0d", colour_class, want.colour));
		if (elapsed_us !== want.elapsed)
			report_mismatch($sformatf("elapsed_us %0d, want %0d", elapsed_us, want.elapsed));
	endtask

	// outputs sampled mid-cycle, the item moves at the next rising edge
	always @(negedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			check_result();
		end
	end

	always @(posedge clk) begin
		if (calm || !arst_n) begin
			out_stall <= 1'b0;
			stall_hold = 0;
		end else if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 60) begin
				out_stall <= 1'b0;
				stall_hold = $urandom_range(0, 6);
			end else if (stall_pick < 92) begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(10, 40);
			end
		end
	end

	initial begin
		lifecycle_event_t ev;
		logic [SRC_W-1:0] tail_src;
		opening_rows = '{
			'{'{32'd0, 16'd1, LC_CREATED, 8'h00, 48'd100}, 1'b1, NOT_TAKEN},
			'{'{32'd1, 16'hFFFF, LC_RUNNING, 8'h00, 48'd100}, 1'b1, NOT_TAKEN},
			'{'{32'd1, 16'd2, LC_RUNNING, 8'h00, 48'd100}, 1'b1, NOT_TAKEN},
			'{'{32'd2, 16'd0, LC_CREATED, 8'h00, 48'd0}, 1'b1,
				'{1'b1, 6'd0, PL_FREE, COL_NEUTRAL, 48'd0}},
			'{'{32'd3, 16'd1, LC_RUNNING, 8'h00, 48'd1000}, 1'b1,
				'{1'b1, 6'd1, PL_FREE, COL_RUNNING, 48'd0}},
			'{'{32'd4, 16'd0, LC_ADOPTED, 8'h80, 48'd1500}, 1'b1,
				'{1'b1, 6'd0, PL_HIT, COL_RUNNING, 48'd500}},
			'{'{32'd5, 16'd2, LC_QUEUED, 8'h7F, 48'd2000}, 1'b1,
				'{1'b1, 6'd2, PL_FREE, COL_ERROR, 48'd1000}},
			'{'{32'd6, 16'd3, LC_RESULT, 8'hFF, 48'd500}, 1'b1,
				'{1'b1, 6'd3, PL_FREE, COL_WAITING, 48'd0}},
			'{'{32'd7, 16'd4, LC_ACCEPTED, 8'h01, 48'hFFFF_FFFF_FFFF}, 1'b0, NOT_TAKEN},
			'{'{32'd8, 16'd5, LC_DISCARDED, 8'h00, 48'd3000}, 1'b0, NOT_TAKEN},
			'{'{32'd9, 16'd6, LC_STOPPING, 8'h00, 48'd3000}, 1'b0, NOT_TAKEN},
			'{'{32'd10, 16'hFFFE, LC_TOP, 8'h00, 48'd4000}, 1'b0, NOT_TAKEN},
			'{'{32'd11, 16'd7, LC_FINISHED, 8'h00, 48'd4000}, 1'b0, NOT_TAKEN},
			'{'{32'd12, 16'd8, LC_ASSIGNED, 8'h00, 48'd4000}, 1'b0, NOT_TAKEN},
			'{'{32'd13, 16'd2, LC_IDLE, 8'h00, 48'd5000}, 1'b0, NOT_TAKEN}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[i]) begin
			pause_sender(sender_gap());
			send_event(opening_rows[i].ev, opening_rows[i].pinned, opening_rows[i].want);
		end

		for (int phase = 1; phase <= 4; phase++) begin
			drain_results();
			repeat (SLOTS + 4) @(posedge clk);
			source_pool[0] = 16'h0000;
			source_pool[1] = 16'hFFFF;
			for (int i = 2; i < 12; i++) begin
				source_pool[i] = SRC_W'($urandom);
			end
			// keep well below the top so the closing items still rise
			if (phase == 4) begin
				seq_head = 32'hC000_0000 + $urandom_range(0, 32'h0FFF_FFFF);
			end else begin
				seq_head = seq_head + $urandom_range(1, 32'h3000_0000);
			end
			case (phase)
				1: write_invalid_source(16'h0000);
				2: write_invalid_source(source_pool[3]);
				3: write_invalid_source(16'hFFFF);
				default: write_invalid_source(SRC_W'($urandom));
			endcase
			for (int n = 0; n < 200; n++) begin
				if (n == 100) begin
					drain_results();
				end
				calm = (n >= 120 && n < 160);
				pause_sender(sender_gap());
				send_event(random_event(), 1'b0, NOT_TAKEN);
			end
			calm = 1'b0;
		end

		// top sequence, then a repeat of it and a zero sequence, both dropped
		tail_src = invalid_src_copy ^ 16'h0001;
		ev = '{32'hFFFF_FFFF, tail_src, LC_FINISHED, 8'h00, time_head};
		send_event(ev, 1'b0, NOT_TAKEN);
		send_event(ev, 1'b1, NOT_TAKEN);
		ev.seq = '0;
		send_event(ev, 1'b1, NOT_TAKEN);

		drain_results();
		repeat (SLOTS + 4) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
